[hw/rtl/tot_pkg.sv]
`default_nettype none

package tot_pkg;

  localparam int TOKEN_W    = 24;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W     = TOKEN_W + PCT_W;
  localparam int CAP_W      = 25;
  localparam int NUM_TIERS  = 3;
  localparam int NUM_PAIRS  = 6;

  // Floor division by 100 as a multiply by a rounded-up reciprocal.
  // This is exact for every dividend below 2**31.
  localparam logic [31:0] RECIP_100       = 32'd2748779070;
  localparam int          RECIP_100_SHIFT = 38;
  // Floor division by 5, exact for every dividend below 2**30.
  localparam logic [27:0] RECIP_5         = 28'd214748365;
  localparam int          RECIP_5_SHIFT   = 30;

  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  typedef enum logic [2:0] {
    FUNC_INSERT = 3'd0,
    FUNC_REMOVE = 3'd1,
    FUNC_MIGRATE = 3'd2,
    FUNC_CLEAR = 3'd3,
    FUNC_STATUS = 3'd4
  } func_t;

  localparam logic [1:0] TIER_HOT  = 2'd0;
  localparam logic [1:0] TIER_WARM = 2'd1;
  localparam logic [1:0] TIER_COLD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CONTEXT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOT_PCT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARM_PCT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLD_PCT = 2'd3;

  localparam logic [2:0] PAIR_HOT_WARM  = 3'd0;
  localparam logic [2:0] PAIR_HOT_COLD  = 3'd1;
  localparam logic [2:0] PAIR_WARM_COLD = 3'd2;
  localparam logic [2:0] PAIR_COLD_WARM = 3'd3;
  localparam logic [2:0] PAIR_WARM_HOT  = 3'd4;
  localparam logic [2:0] PAIR_COLD_HOT  = 3'd5;
  localparam logic [2:0] PAIR_NONE      = 3'd6;

  localparam logic [3:0] SEL_MIG_LAST  = 4'd5;
  localparam logic [3:0] SEL_CAP_HOT   = 4'd6;
  localparam logic [3:0] SEL_CAP_WARM  = 4'd7;
  localparam logic [3:0] SEL_CAP_COLD  = 4'd8;

  typedef struct packed {
    logic [2:0]         func;
    logic [TOKEN_W-1:0] token_count;
    logic [1:0]         from_tier;
    logic [1:0]         to_tier;
    logic [3:0]         read_select;
  } req_t;

  typedef struct packed {
    logic [NUM_TIERS-1:0][CAP_W-1:0] cap;
    logic [CAP_W-1:0]                hot_thr;
    logic [CAP_W-1:0]                hot_tgt;
  } cap_info_t;

  function automatic logic [2:0] pair_index(input logic [1:0] f, input logic [1:0] t);
    logic [2:0] p;
    case ({f, t})
      {TIER_HOT, TIER_WARM}:  p = PAIR_HOT_WARM;
      {TIER_HOT, TIER_COLD}:  p = PAIR_HOT_COLD;
      {TIER_WARM, TIER_COLD}: p = PAIR_WARM_COLD;
      {TIER_COLD, TIER_WARM}: p = PAIR_COLD_WARM;
      {TIER_WARM, TIER_HOT}:  p = PAIR_WARM_HOT;
      {TIER_COLD, TIER_HOT}:  p = PAIR_COLD_HOT;
      default:                p = PAIR_NONE;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tot_req_if.sv]
`default_nettype none

interface tot_req_if
  import tot_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [TOKEN_W-1:0] token_count;
  logic [1:0]         from_tier;
  logic [1:0]         to_tier;
  logic [3:0]         read_select;

  modport source (output valid, func, token_count, from_tier, to_tier, read_select,
                  input ready);
  modport sink (input valid, func, token_count, from_tier, to_tier, read_select,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/tot_rsp_if.sv]
`default_nettype none

interface tot_rsp_if #(
  parameter int LEVEL_WIDTH = 24,
  parameter int MIGRATION_WIDTH = 32
) ();
  logic                       valid;
  logic                       ready;
  logic [LEVEL_WIDTH-1:0]     hot_level;
  logic [LEVEL_WIDTH-1:0]     warm_level;
  logic [LEVEL_WIDTH-1:0]     cold_level;
  logic [LEVEL_WIDTH-1:0]     hot_max;
  logic [LEVEL_WIDTH-1:0]     warm_max;
  logic [LEVEL_WIDTH-1:0]     cold_max;
  logic                       pressure;
  logic [LEVEL_WIDTH-1:0]     evict_advice;
  logic [MIGRATION_WIDTH-1:0] read_value;

  modport source (output valid, hot_level, warm_level, cold_level, hot_max, warm_max,
                  cold_max, pressure, evict_advice, read_value, input ready);
  modport sink (input valid, hot_level, warm_level, cold_level, hot_max, warm_max,
                cold_max, pressure, evict_advice, read_value, output ready);
endinterface

`default_nettype wire

[hw/rtl/tot_cfg_if.sv]
`default_nettype none

interface tot_cfg_if
  import tot_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/tot_cap_unit.sv]
`default_nettype none

module tot_cap_unit
  import tot_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cap_info_t                  caps,
  output logic                       settled
);

  localparam int Q100_W = PROD_W + 32;
  localparam int X_W    = CAP_W + 2;
  localparam int Q5_W   = X_W + 28;

  logic [TOKEN_W-1:0]                 context_size;
  logic [NUM_TIERS-1:0][PCT_W-1:0]    pct;
  logic [1:0]                         wait_cnt;
  logic [NUM_TIERS-1:0][PROD_W-1:0]   prod;
  logic [NUM_TIERS-1:0][CAP_W-1:0]    cap;
  logic [CAP_W-1:0]                   hot_thr;
  logic [CAP_W-1:0]                   hot_tgt;
  logic [NUM_TIERS-1:0][Q100_W-1:0]   q100;
  logic [X_W-1:0]                     x4;
  logic [X_W-1:0]                     x3;
  logic [Q5_W-1:0]                    q4;
  logic [Q5_W-1:0]                    q3;

  always_ff @(posedge clk) begin
    if (rst) begin
      context_size <= '0;
      pct <= '0;
      wait_cnt <= SETTLE_CYCLES;
    end else if (wr_en) begin
      case (wr_index)
        REG_CONTEXT:  context_size <= wr_data[TOKEN_W-1:0];
        REG_HOT_PCT:  pct[TIER_HOT] <= wr_data[PCT_W-1:0];
        REG_WARM_PCT: pct[TIER_WARM] <= wr_data[PCT_W-1:0];
        REG_COLD_PCT: pct[TIER_COLD] <= wr_data[PCT_W-1:0];
        default: ;
      endcase
      wait_cnt <= SETTLE_CYCLES;
    end else if (wait_cnt != 2'd0) begin
      wait_cnt <= wait_cnt - 2'd1;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_TIERS; i++) begin
      q100[i] = Q100_W'(prod[i]) * Q100_W'(RECIP_100);
    end
    x4 = {cap[TIER_HOT], 2'b00};
    x3 = X_W'(cap[TIER_HOT]) + X_W'({cap[TIER_HOT], 1'b0});
    q4 = Q5_W'(x4) * Q5_W'(RECIP_5);
    q3 = Q5_W'(x3) * Q5_W'(RECIP_5);
  end

  // Three register stages: product, capacity, hot thresholds.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_TIERS; i++) begin
      prod[i] <= PROD_W'(context_size) * PROD_W'(pct[i]);
      cap[i] <= q100[i][RECIP_100_SHIFT +: CAP_W];
    end
    hot_thr <= q4[RECIP_5_SHIFT +: CAP_W];
    hot_tgt <= q3[RECIP_5_SHIFT +: CAP_W];
  end

  assign caps.cap = cap;
  assign caps.hot_thr = hot_thr;
  assign caps.hot_tgt = hot_tgt;
  assign settled = (wait_cnt == 2'd0);

  a_write_unsettles: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> !settled)
    else $error("capacity pipeline reported settled right after a register write");

endmodule

`default_nettype wire

[hw/rtl/tot_state_unit.sv]
`default_nettype none

module tot_state_unit
  import tot_pkg::*;
#(
  parameter int LEVEL_WIDTH = 24,
  parameter int MIGRATION_WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  advance,
  input  wire req_t                                  item,
  input  wire cap_info_t                             caps,
  output logic [NUM_TIERS-1:0][LEVEL_WIDTH-1:0]      level_out,
  output logic [NUM_TIERS-1:0][LEVEL_WIDTH-1:0]      peak_out,
  output logic                                       pressure_out,
  output logic [LEVEL_WIDTH-1:0]                     evict_out,
  output logic [MIGRATION_WIDTH-1:0]                 read_out
);

  localparam int SUM_W = (LEVEL_WIDTH > TOKEN_W ? LEVEL_WIDTH : TOKEN_W) + 1;
  localparam int MS_W  = (MIGRATION_WIDTH > TOKEN_W ? MIGRATION_WIDTH : TOKEN_W) + 1;
  localparam int PR_W  = (LEVEL_WIDTH + 3 > CAP_W + 2 ? LEVEL_WIDTH + 3 : CAP_W + 2) + 1;
  localparam int CMP_W = (LEVEL_WIDTH > CAP_W ? LEVEL_WIDTH : CAP_W) + 1;

  logic [NUM_TIERS-1:0][LEVEL_WIDTH-1:0]     levels;
  logic [NUM_TIERS-1:0][LEVEL_WIDTH-1:0]     peaks;
  logic [NUM_PAIRS-1:0][MIGRATION_WIDTH-1:0] migs;
  logic [NUM_TIERS-1:0][LEVEL_WIDTH-1:0]     levels_next;
  logic [NUM_TIERS-1:0][LEVEL_WIDTH-1:0]     peaks_next;
  logic [NUM_PAIRS-1:0][MIGRATION_WIDTH-1:0] migs_next;
  logic [2:0]                                pair;
  logic                                      mig_ok;
  logic [PR_W-1:0]                           hot5;
  logic [PR_W-1:0]                           cap4;
  logic [CMP_W-1:0]                          hot_c;
  logic [63:0]                               cap_wide;

  function automatic logic [LEVEL_WIDTH-1:0] sat_add(input logic [LEVEL_WIDTH-1:0] a,
                                                     input logic [TOKEN_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    return (s > SUM_W'({LEVEL_WIDTH{1'b1}})) ? {LEVEL_WIDTH{1'b1}} : s[LEVEL_WIDTH-1:0];
  endfunction

  function automatic logic [LEVEL_WIDTH-1:0] floor_sub(input logic [LEVEL_WIDTH-1:0] a,
                                                       input logic [TOKEN_W-1:0] b);
    logic [SUM_W-1:0] d;
    d = SUM_W'(a) - SUM_W'(b);
    return (SUM_W'(b) >= SUM_W'(a)) ? '0 : d[LEVEL_WIDTH-1:0];
  endfunction

  function automatic logic [MIGRATION_WIDTH-1:0] mig_add(
    input logic [MIGRATION_WIDTH-1:0] a, input logic [TOKEN_W-1:0] b);
    logic [MS_W-1:0] s;
    s = MS_W'(a) + MS_W'(b);
    return (s > MS_W'({MIGRATION_WIDTH{1'b1}})) ? {MIGRATION_WIDTH{1'b1}}
                                                 : s[MIGRATION_WIDTH-1:0];
  endfunction

  always_comb begin
    levels_next = levels;
    peaks_next = peaks;
    migs_next = migs;
    pair = pair_index(item.from_tier, item.to_tier);
    mig_ok = (item.token_count != '0) && (pair != PAIR_NONE);
    case (item.func)
      FUNC_INSERT: begin
        levels_next[TIER_HOT] = sat_add(levels[TIER_HOT], item.token_count);
        if (levels_next[TIER_HOT] > peaks[TIER_HOT]) begin
          peaks_next[TIER_HOT] = levels_next[TIER_HOT];
        end
      end
      FUNC_REMOVE: begin
        levels_next[TIER_HOT] = floor_sub(levels[TIER_HOT], item.token_count);
      end
      FUNC_MIGRATE: begin
        if (mig_ok) begin
          levels_next[item.from_tier] = floor_sub(levels[item.from_tier], item.token_count);
          levels_next[item.to_tier] = sat_add(levels[item.to_tier], item.token_count);
          if (levels_next[item.to_tier] > peaks[item.to_tier]) begin
            peaks_next[item.to_tier] = levels_next[item.to_tier];
          end
          migs_next[pair] = mig_add(migs[pair], item.token_count);
        end
      end
      FUNC_CLEAR: begin
        levels_next = '0;
        peaks_next = '0;
        migs_next = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    hot5 = PR_W'(levels_next[TIER_HOT]) + (PR_W'(levels_next[TIER_HOT]) << 2);
    cap4 = PR_W'(caps.cap[TIER_HOT]) << 2;
    hot_c = CMP_W'(levels_next[TIER_HOT]);
    pressure_out = (caps.cap[TIER_HOT] != '0) && (hot5 >= cap4);
    evict_out = '0;
    if ((caps.cap[TIER_HOT] != '0) && (hot_c >= CMP_W'(caps.hot_thr)) &&
        (hot_c > CMP_W'(caps.hot_tgt))) begin
      evict_out = LEVEL_WIDTH'(hot_c - CMP_W'(caps.hot_tgt));
    end
  end

  always_comb begin
    cap_wide = '0;
    if (item.read_select <= SEL_MIG_LAST) begin
      read_out = migs_next[item.read_select[2:0]];
    end else begin
      case (item.read_select)
        SEL_CAP_HOT:  cap_wide = 64'(caps.cap[TIER_HOT]);
        SEL_CAP_WARM: cap_wide = 64'(caps.cap[TIER_WARM]);
        SEL_CAP_COLD: cap_wide = 64'(caps.cap[TIER_COLD]);
        default:      cap_wide = '0;
      endcase
      read_out = cap_wide[MIGRATION_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= '0;
      peaks <= '0;
      migs <= '0;
    end else if (advance) begin
      levels <= levels_next;
      peaks <= peaks_next;
      migs <= migs_next;
    end
  end

  assign level_out = levels_next;
  assign peak_out = peaks_next;

  a_peak_covers_level: assert property (@(posedge clk) disable iff (rst)
    (peaks[TIER_HOT] >= levels[TIER_HOT]) && (peaks[TIER_WARM] >= levels[TIER_WARM]) &&
    (peaks[TIER_COLD] >= levels[TIER_COLD]))
    else $error("a tier peak fell below its level");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    advance && (item.func == FUNC_CLEAR) |=> (levels == '0) && (peaks == '0) && (migs == '0))
    else $error("statistics not cleared");

  a_pressure_needs_cap: assert property (@(posedge clk) disable iff (rst)
    pressure_out |-> (caps.cap[TIER_HOT] != '0))
    else $error("pressure raised with zero hot capacity");

endmodule

`default_nettype wire

[hw/rtl/tier_occupancy_tracker.sv]
`default_nettype none

// Tracks the token counts and peaks of the hot, warm and cold tiers and six
// migration totals. One request is accepted per clock cycle unless the response
// stalls or capacities are settling; each response passes through an input
// register and an output register, so a stalled response does not stop the next
// request from entering. Tier capacities come from a three-stage pipeline behind
// the configuration registers; after each configuration write the request channel
// is held off while that pipeline settles. Configuration writes are always
// accepted and must only be issued while no request is in flight.
module tier_occupancy_tracker
  import tot_pkg::*;
#(
  parameter int LEVEL_WIDTH = 24,
  parameter int MIGRATION_WIDTH = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  tot_req_if.sink    req,
  tot_rsp_if.source  rsp,
  tot_cfg_if.sink    cfg
);

  logic                                  in_valid;
  req_t                                  item;
  logic                                  advance;
  logic                                  settled;
  cap_info_t                             caps;
  logic [NUM_TIERS-1:0][LEVEL_WIDTH-1:0] level_c;
  logic [NUM_TIERS-1:0][LEVEL_WIDTH-1:0] peak_c;
  logic                                  pressure_c;
  logic [LEVEL_WIDTH-1:0]                evict_c;
  logic [MIGRATION_WIDTH-1:0]            read_c;
  logic                                  out_valid;
  logic [NUM_TIERS-1:0][LEVEL_WIDTH-1:0] level_q;
  logic [NUM_TIERS-1:0][LEVEL_WIDTH-1:0] peak_q;
  logic                                  pressure_q;
  logic [LEVEL_WIDTH-1:0]                evict_q;
  logic [MIGRATION_WIDTH-1:0]            read_q;

  tot_cap_unit u_cap (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .caps     (caps),
    .settled  (settled)
  );

  tot_state_unit #(
    .LEVEL_WIDTH     (LEVEL_WIDTH),
    .MIGRATION_WIDTH (MIGRATION_WIDTH)
  ) u_state (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .item         (item),
    .caps         (caps),
    .level_out    (level_c),
    .peak_out     (peak_c),
    .pressure_out (pressure_c),
    .evict_out    (evict_c),
    .read_out     (read_c)
  );

  assign cfg.ready = 1'b1;
  assign advance = in_valid && (!out_valid || rsp.ready);
  assign req.ready = settled && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.func <= req.func;
      item.token_count <= req.token_count;
      item.from_tier <= req.from_tier;
      item.to_tier <= req.to_tier;
      item.read_select <= req.read_select;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      level_q <= level_c;
      peak_q <= peak_c;
      pressure_q <= pressure_c;
      evict_q <= evict_c;
      read_q <= read_c;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.hot_level = level_q[TIER_HOT];
  assign rsp.warm_level = level_q[TIER_WARM];
  assign rsp.cold_level = level_q[TIER_COLD];
  assign rsp.hot_max = peak_q[TIER_HOT];
  assign rsp.warm_max = peak_q[TIER_WARM];
  assign rsp.cold_max = peak_q[TIER_COLD];
  assign rsp.pressure = pressure_q;
  assign rsp.evict_advice = evict_q;
  assign rsp.read_value = read_q;

  a_held_request_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(item))
    else $error("a waiting request was lost or overwritten");

endmodule

`default_nettype wire

[verif/tb_tier_occupancy_tracker.sv]
`default_nettype none

module tb_tier_occupancy_tracker;
  import tot_pkg::*;

  localparam int NUM_DIR = 25;
  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_ITEMS = 60;
  localparam int SOAK_ITEMS = 300;

  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam logic [1:0] TIER_NONE = 2'd3;
  localparam logic [3:0] SEL_SPARE_LO = 4'd9;
  localparam logic [3:0] SEL_SPARE_HI = 4'd15;
  localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

  localparam logic [2:0] PAIR_OF [3][3] = '{
    '{PAIR_NONE, PAIR_HOT_WARM, PAIR_HOT_COLD},
    '{PAIR_WARM_HOT, PAIR_NONE, PAIR_WARM_COLD},
    '{PAIR_COLD_HOT, PAIR_COLD_WARM, PAIR_NONE}
  };

  typedef struct packed {
    logic [23:0] hot_level;
    logic [23:0] warm_level;
    logic [23:0] cold_level;
    logic [23:0] hot_max;
    logic [23:0] warm_max;
    logic [23:0] cold_max;
    logic        pressure;
    logic [23:0] evict_advice;
    logic [31:0] read_value;
  } status_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [23:0] count;
    logic [1:0]  src;
    logic [1:0]  dst;
    logic [3:0]  sel;
    logic        typed;
    status_t     want;
  } dir_row_t;

  logic clk;
  logic rst;

  tot_req_if req_if();
  tot_rsp_if rsp_if();
  tot_cfg_if cfg_if();

  tier_occupancy_tracker i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  logic [23:0] tier_level [3];
  logic [23:0] tier_peak [3];
  logic [31:0] pair_total [6];
  logic [23:0] cfg_context;
  logic [6:0]  tier_pct [3];

  status_t pending_status [$];
  bit      steady;
  int      mismatches;
  int      sent;
  int      checked;
  int      settings;
  int      cycle_count;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{FUNC_STATUS, 24'd0, TIER_HOT, TIER_HOT, 4'(PAIR_HOT_WARM), 1'b1, '0},
    '{FUNC_STATUS, 24'd0, TIER_HOT, TIER_HOT, SEL_CAP_HOT, 1'b1,
      '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 24'd0, 32'd500}},
    '{FUNC_STATUS, 24'd0, TIER_HOT, TIER_HOT, SEL_CAP_COLD, 1'b1,
      '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 24'd0, 32'd1270}},
    '{FUNC_STATUS, 24'd0, TIER_HOT, TIER_HOT, SEL_SPARE_HI, 1'b1, '0},
    '{FUNC_INSERT, 24'd400, TIER_HOT, TIER_HOT, 4'(PAIR_HOT_WARM), 1'b1,
      '{24'd400, 24'd0, 24'd0, 24'd400, 24'd0, 24'd0, 1'b1, 24'd100, 32'd0}},
    '{FUNC_INSERT, 24'd0, TIER_HOT, TIER_HOT, SEL_CAP_WARM, 1'b0, '0},
    '{FUNC_REMOVE, 24'd1, TIER_HOT, TIER_HOT, 4'(PAIR_HOT_WARM), 1'b0, '0},
    '{FUNC_MIGRATE, 24'd100, TIER_HOT, TIER_WARM, 4'(PAIR_HOT_WARM), 1'b0, '0},
    '{FUNC_MIGRATE, 24'd50, TIER_HOT, TIER_COLD, 4'(PAIR_HOT_COLD), 1'b0, '0},
    '{FUNC_MIGRATE, 24'd1000, TIER_WARM, TIER_COLD, 4'(PAIR_WARM_COLD), 1'b0, '0},
    '{FUNC_MIGRATE, 24'd7, TIER_COLD, TIER_WARM, 4'(PAIR_COLD_WARM), 1'b0, '0},
    '{FUNC_MIGRATE, 24'd3, TIER_WARM, TIER_HOT, 4'(PAIR_WARM_HOT), 1'b0, '0},
    '{FUNC_MIGRATE, 24'd20, TIER_COLD, TIER_HOT, 4'(PAIR_COLD_HOT), 1'b0, '0},
    '{FUNC_MIGRATE, 24'd0, TIER_COLD, TIER_HOT, 4'(PAIR_COLD_HOT), 1'b0, '0},
    '{FUNC_MIGRATE, 24'd5, TIER_WARM, TIER_WARM, SEL_SPARE_LO, 1'b0, '0},
    '{FUNC_MIGRATE, 24'd10, TIER_NONE, TIER_HOT, 4'(PAIR_HOT_WARM), 1'b0, '0},
    '{FUNC_MIGRATE, 24'd10, TIER_HOT, TIER_NONE, 4'(PAIR_HOT_COLD), 1'b0, '0},
    '{FUNC_REMOVE, COUNT_MAX, TIER_HOT, TIER_HOT, SEL_CAP_HOT, 1'b0, '0},
    '{FUNC_INSERT, COUNT_MAX, TIER_HOT, TIER_HOT, SEL_CAP_HOT, 1'b0, '0},
    '{FUNC_INSERT, COUNT_MAX, TIER_HOT, TIER_HOT, SEL_CAP_HOT, 1'b0, '0},
    '{FUNC_MIGRATE, COUNT_MAX, TIER_HOT, TIER_WARM, 4'(PAIR_HOT_WARM), 1'b0, '0},
    '{FUNC_SPARE_LO, 24'd9, TIER_COLD, TIER_HOT, SEL_CAP_HOT, 1'b0, '0},
    '{FUNC_SPARE_HI, COUNT_MAX, TIER_HOT, TIER_WARM, 4'(PAIR_HOT_WARM), 1'b0, '0},
    '{FUNC_CLEAR, 24'd0, TIER_HOT, TIER_HOT, 4'(PAIR_HOT_WARM), 1'b1, '0},
    '{FUNC_STATUS, 24'd0, TIER_HOT, TIER_HOT, SEL_CAP_COLD, 1'b1,
      '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 24'd0, 32'd1270}}
  };

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding.",
               cycle_count, pending_status.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [24:0] tier_capacity(input int t);
    logic [63:0] prod;
    prod = 64'(cfg_context) * 64'(tier_pct[t]);
    return 25'(prod / 64'd100);
  endfunction

  function automatic void add_tokens(input int t, input logic [23:0] n);
    logic [24:0] sum;
    sum = {1'b0, tier_level[t]} + {1'b0, n};
    tier_level[t] = sum[24] ? COUNT_MAX : sum[23:0];
    if (tier_level[t] > tier_peak[t]) tier_peak[t] = tier_level[t];
  endfunction

  function automatic void take_tokens(input int t, input logic [23:0] n);
    tier_level[t] = (n >= tier_level[t]) ? 24'd0 : tier_level[t] - n;
  endfunction

  function automatic void clear_tracker();
    for (int i = 0; i < 3; i++) begin
      tier_level[i] = '0;
      tier_peak[i] = '0;
    end
    for (int i = 0; i < 6; i++) pair_total[i] = '0;
  endfunction

  function automatic status_t track_request(input logic [2:0] f, input logic [23:0] n,
                                            input logic [1:0] src, input logic [1:0] dst,
                                            input logic [3:0] sel);
    status_t s;
    logic [2:0] pair;
    logic [32:0] total;
    logic [24:0] cap;
    logic [63:0] hot;
    logic [63:0] thr;
    logic [63:0] tgt;
    case (f)
      FUNC_INSERT: add_tokens(TIER_HOT, n);
      FUNC_REMOVE: take_tokens(TIER_HOT, n);
      FUNC_MIGRATE: begin
        if (n != 0 && src != dst && src <= TIER_COLD && dst <= TIER_COLD) begin
          pair = PAIR_OF[src][dst];
          take_tokens(src, n);
          add_tokens(dst, n);
          total = {1'b0, pair_total[pair]} + 33'(n);
          pair_total[pair] = total[32] ? 32'hFFFFFFFF : total[31:0];
        end
      end
      FUNC_CLEAR: clear_tracker();
      default: ;
    endcase
    s = '0;
    cap = tier_capacity(TIER_HOT);
    hot = 64'(tier_level[TIER_HOT]);
    if (cap != 0) begin
      s.pressure = (hot * 5 >= 64'(cap) * 4);
      thr = (64'(cap) * 4) / 5;
      tgt = (64'(cap) * 3) / 5;
      if (hot >= thr && hot > tgt) s.evict_advice = 24'(hot - tgt);
    end
    if (sel <= SEL_MIG_LAST) s.read_value = pair_total[sel];
    else if (sel >= SEL_CAP_HOT && sel <= SEL_CAP_COLD)
      s.read_value = 32'(tier_capacity(int'(sel - SEL_CAP_HOT)));
    s.hot_level = tier_level[TIER_HOT];
    s.warm_level = tier_level[TIER_WARM];
    s.cold_level = tier_level[TIER_COLD];
    s.hot_max = tier_peak[TIER_HOT];
    s.warm_max = tier_peak[TIER_WARM];
    s.cold_max = tier_peak[TIER_COLD];
    return s;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  task automatic send_request(input logic [2:0] f, input logic [23:0] n,
                              input logic [1:0] src, input logic [1:0] dst,
                              input logic [3:0] sel, input logic typed,
                              input status_t want);
    int gap;
    status_t s;
    gap = steady ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.func <= f;
    req_if.token_count <= n;
    req_if.from_tier <= src;
    req_if.to_tier <= dst;
    req_if.read_select <= sel;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    s = track_request(f, n, src, dst, sel);
    pending_status.push_back(typed ? want : s);
    sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_CONTEXT: cfg_context = value;
      REG_HOT_PCT: tier_pct[TIER_HOT] = value[6:0];
      REG_WARM_PCT: tier_pct[TIER_WARM] = value[6:0];
      REG_COLD_PCT: tier_pct[TIER_COLD] = value[6:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [23:0] context_size, input logic [6:0] hot_share,
                           input logic [6:0] warm_share, input logic [6:0] cold_share);
    logic [23:0] junk;
    wait_drained();
    repeat (4) @(posedge clk);
    junk = 24'($urandom);
    write_reg(REG_CONTEXT, context_size);
    write_reg(REG_HOT_PCT, {junk[23:7], hot_share});
    write_reg(REG_WARM_PCT, {junk[16:0], warm_share});
    write_reg(REG_COLD_PCT, {junk[20:4], cold_share});
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    settings++;
  endtask

  task automatic run_random(input int count, input bit soak);
    logic [2:0]  f;
    logic [23:0] n;
    logic [1:0]  src;
    logic [1:0]  dst;
    logic [3:0]  sel;
    logic [24:0] scale;
    int          pick;
    for (int k = 0; k < count; k++) begin
      if (k % 20 == 0) steady = ($urandom_range(0, 2) == 0);
      if (k == count / 2) wait_drained();
      scale = tier_capacity(TIER_HOT) >> 2;
      if (scale < 25'd16) scale = 25'd16;
      if (scale > 25'(COUNT_MAX)) scale = 25'(COUNT_MAX);
      pick = $urandom_range(0, 99);
      if (pick < 30) f = FUNC_INSERT;
      else if (pick < 50) f = FUNC_REMOVE;
      else if (pick < 82) f = FUNC_MIGRATE;
      else if (pick < 85) f = FUNC_CLEAR;
      else if (pick < 95) f = FUNC_STATUS;
      else f = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
      case ($urandom_range(0, 9))
        0: n = '0;
        1: n = COUNT_MAX;
        2: n = 24'($urandom);
        3: n = 24'(1) << $urandom_range(0, 23);
        default: n = 24'($urandom_range(0, int'(scale)));
      endcase
      src = ($urandom_range(0, 9) == 0) ? TIER_NONE : 2'($urandom_range(0, 2));
      dst = ($urandom_range(0, 9) == 0) ? TIER_NONE : 2'($urandom_range(0, 2));
      sel = 4'($urandom_range(0, 15));
      if (soak) begin
        if (f == FUNC_CLEAR) f = FUNC_STATUS;
        if ($urandom_range(0, 19) != 0) begin
          f = FUNC_MIGRATE;
          n = COUNT_MAX;
          src = TIER_HOT;
          dst = TIER_WARM;
          if ($urandom_range(0, 1) == 0) sel = 4'(PAIR_HOT_WARM);
        end
      end
      send_request(f, n, src, dst, sel, 1'b0, '0);
    end
  endtask

  initial begin
    int gap;
    status_t got;
    status_t want;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
        @(negedge clk);
        rsp_if.ready <= 1'b0;
      end
      @(negedge clk);
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
      got = '{rsp_if.hot_level, rsp_if.warm_level, rsp_if.cold_level, rsp_if.hot_max,
              rsp_if.warm_max, rsp_if.cold_max, rsp_if.pressure, rsp_if.evict_advice,
              rsp_if.read_value};
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t: response with none expected, hot_level %0d read_value %0d",
                 $time, got.hot_level, got.read_value);
      end else begin
        want = pending_status.pop_front();
        check_field("hot_level", 32'(want.hot_level), 32'(got.hot_level));
        check_field("warm_level", 32'(want.warm_level), 32'(got.warm_level));
        check_field("cold_level", 32'(want.cold_level), 32'(got.cold_level));
        check_field("hot_max", 32'(want.hot_max), 32'(got.hot_max));
        check_field("warm_max", 32'(want.warm_max), 32'(got.warm_max));
        check_field("cold_max", 32'(want.cold_max), 32'(got.cold_max));
        check_field("pressure", 32'(want.pressure), 32'(got.pressure));
        check_field("evict_advice", 32'(want.evict_advice), 32'(got.evict_advice));
        check_field("read_value", want.read_value, got.read_value);
        checked++;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.func <= FUNC_STATUS;
    req_if.token_count <= '0;
    req_if.from_tier <= TIER_HOT;
    req_if.to_tier <= TIER_HOT;
    req_if.read_select <= '0;
    rsp_if.ready <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_CONTEXT;
    cfg_if.data <= '0;
    steady = 1'b0;
    cfg_context = '0;
    for (int i = 0; i < 3; i++) tier_pct[i] = '0;
    clear_tracker();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    configure(24'd1000, 7'd50, 7'd30, 7'd127);
    foreach (dir_rows[i])
      send_request(dir_rows[i].func, dir_rows[i].count, dir_rows[i].src, dir_rows[i].dst,
                   dir_rows[i].sel, dir_rows[i].typed, dir_rows[i].want);

    configure(24'($urandom), 7'($urandom_range(10, 100)), 7'($urandom_range(0, 100)),
              7'($urandom_range(0, 100)));
    run_random(PHASE_ITEMS, 1'b0);
    configure(COUNT_MAX, 7'd127, 7'd0, 7'd100);
    run_random(PHASE_ITEMS, 1'b0);
    configure(24'd0, 7'd0, 7'd0, 7'd0);
    run_random(PHASE_ITEMS, 1'b0);
    configure(24'($urandom_range(1, 200)), 7'($urandom_range(0, 127)),
              7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    run_random(PHASE_ITEMS, 1'b0);
    configure(24'($urandom), 7'd0, 7'd127, 7'($urandom_range(0, 127)));
    run_random(PHASE_ITEMS, 1'b0);
    configure(24'($urandom_range(1000, 100000)), 7'd80, 7'd15, 7'd5);
    run_random(SOAK_ITEMS, 1'b1);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d requests under %0d register settings, checked %0d responses.",
             sent, settings, checked);
    $display("Stimulus covered all commands, spare codes, floors, saturation and %s",
             "zero capacity.");
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d responses missing.", mismatches, pending_status.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
